@@ sv/fpss_pkg.sv @@
// Shared constants, register codes, the cell operand struct and saturation helpers
// for the five-point stencil sweep. No dependencies.
package fpss_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field and register widths
    localparam int SAMPLE_W   = 32;
    localparam int ROW_W      = 16;
    localparam int GW_W       = 11;
    localparam int GH_W       = 16;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 64;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA        = 2'd3;

    // Register reset values
    localparam logic [GW_W-1:0]   GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GH_W-1:0]   GRID_HEIGHT_RST = 16'd1024;
    localparam logic [COEF_W-1:0] ALPHA_RST       = 16'd5741;
    localparam logic [COEF_W-1:0] BETA_RST        = 16'd5014;

    // Grid size limits after clamping
    localparam logic [GW_W-1:0] GW_MIN = 11'd3;
    localparam logic [GW_W-1:0] GW_MAX = GW_W'(MAX_WIDTH);
    localparam logic [GH_W-1:0] GH_MIN = 16'd3;

    // Saturation bounds
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Operands of one interior cell update
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] cen;
        logic signed [SAMPLE_W-1:0] north;
        logic signed [SAMPLE_W-1:0] south;
        logic signed [SAMPLE_W-1:0] west;
        logic signed [SAMPLE_W-1:0] east;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic                       last;
    } fpss_cell_t;

    // Clamp a 35-bit neighbor sum to 32 bits
    function automatic logic signed [SAMPLE_W-1:0] sat_nsum(input logic signed [34:0] x);
        logic ok;
        ok = (x[34:31] == {4{x[34]}});
        if (ok)
            return x[31:0];
        else if (x[34])
            return SAT_MIN;
        else
            return SAT_MAX;
    endfunction

    // Clamp a 34-bit weighted sum to 32 bits
    function automatic logic signed [SAMPLE_W-1:0] sat_value(input logic signed [33:0] x);
        logic ok;
        ok = (x[33:31] == {3{x[33]}});
        if (ok)
            return x[31:0];
        else if (x[33])
            return SAT_MIN;
        else
            return SAT_MAX;
    endfunction

endpackage

@@ sv/fpss_ram.sv @@
// Generic single-write, single-read RAM with registered read-first output.
// No dependencies.
module fpss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read in the same edge: a read of the written address returns old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/fpss_update.sv @@
// Three-stage arithmetic pipeline for one interior cell: neighbor sum, weight
// products, shift/add/saturate. Depends on fpss_pkg.
module fpss_update (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  fpss_pkg::fpss_cell_t                 in_cell,
    input  logic [fpss_pkg::COEF_W-1:0]          alpha,
    input  logic [fpss_pkg::COEF_W-1:0]          beta,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fpss_pkg::SAMPLE_W-1:0] out_value,
    output logic [fpss_pkg::ROW_W-1:0]           out_row,
    output logic [fpss_pkg::COL_W-1:0]           out_col,
    output logic                                 out_last
);
    import fpss_pkg::*;

    // Stage B: saturated neighbor sum
    logic                       vb_reg;
    logic signed [SAMPLE_W-1:0] nsum_b_reg;
    logic signed [SAMPLE_W-1:0] cen_b_reg;
    logic [ROW_W-1:0]           row_b_reg;
    logic [COL_W-1:0]           col_b_reg;
    logic                       last_b_reg;

    // Stage C: weight products
    logic                       vc_reg;
    logic signed [48:0]         pa_c_reg;
    logic signed [48:0]         pb_c_reg;
    logic [ROW_W-1:0]           row_c_reg;
    logic [COL_W-1:0]           col_c_reg;
    logic                       last_c_reg;

    // Stage D: result register
    logic                       vd_reg;
    logic signed [SAMPLE_W-1:0] value_d_reg;
    logic [ROW_W-1:0]           row_d_reg;
    logic [COL_W-1:0]           col_d_reg;
    logic                       last_d_reg;

    logic                       ready_b;
    logic                       ready_c;
    logic                       ready_d;
    logic signed [34:0]         nsum_wide;
    logic signed [48:0]         pa_next;
    logic signed [48:0]         pb_next;
    logic signed [33:0]         value_wide;

    // Each stage moves when the next one is empty or moving
    assign ready_d  = !vd_reg || out_ready;
    assign ready_c  = !vc_reg || ready_d;
    assign ready_b  = !vb_reg || ready_c;
    assign in_ready = ready_b;

    // North + south + west + east + 2 * center, full precision
    assign nsum_wide = {{3{in_cell.north[31]}}, in_cell.north}
                     + {{3{in_cell.south[31]}}, in_cell.south}
                     + {{3{in_cell.west[31]}},  in_cell.west}
                     + {{3{in_cell.east[31]}},  in_cell.east}
                     + {{2{in_cell.cen[31]}},   in_cell.cen, 1'b0};

    // Unsigned Q0.16 weights times signed samples
    assign pa_next = $signed({1'b0, alpha}) * cen_b_reg;
    assign pb_next = $signed({1'b0, beta}) * nsum_b_reg;

    // Arithmetic shift right by 16 is the upper slice of each product
    assign value_wide = {pa_c_reg[48], pa_c_reg[48:16]} + {pb_c_reg[48], pb_c_reg[48:16]};

    // Stage B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (ready_b)
        begin
            vb_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && in_valid)
        begin
            nsum_b_reg <= sat_nsum(nsum_wide);
            cen_b_reg  <= in_cell.cen;
            row_b_reg  <= in_cell.row;
            col_b_reg  <= in_cell.col;
            last_b_reg <= in_cell.last;
        end
    end

    // Stage C
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (ready_c)
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && vb_reg)
        begin
            pa_c_reg   <= pa_next;
            pb_c_reg   <= pb_next;
            row_c_reg  <= row_b_reg;
            col_c_reg  <= col_b_reg;
            last_c_reg <= last_b_reg;
        end
    end

    // Stage D
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else if (ready_d)
        begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_d && vc_reg)
        begin
            value_d_reg <= sat_value(value_wide);
            row_d_reg   <= row_c_reg;
            col_d_reg   <= col_c_reg;
            last_d_reg  <= last_c_reg;
        end
    end

    assign out_valid = vd_reg;
    assign out_value = value_d_reg;
    assign out_row   = row_d_reg;
    assign out_col   = col_d_reg;
    assign out_last  = last_d_reg;

endmodule

@@ sv/five_point_stencil_sweep.sv @@
// Top level of the five-point stencil sweep: position counters, line stores,
// operand stage and configuration registers. Depends on fpss_pkg, fpss_ram, fpss_update.
//
//  channel | direction | signals                              | contents
//  --------+-----------+--------------------------------------+------------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser    | sample, start_req
//  m_*     | out       | m_tvalid m_tready m_tdata m_tlast    | value, row, col; last
//  cfg_*   | in        | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
// One sample is taken every cycle while s_tready is high; its result reaches m_tvalid
// through the operand register, which loads on the edge that takes the sample with the
// line store read, then neighbor sum, products and saturation - one register each.
// Reset sets the position to row 0, column 0 and the registers to their defaults;
// the line stores are not cleared and hold nothing valid until a row has streamed in.
// When m_tready is low the four stages fill up; s_tready falls only once every stage
// holds a result. Border samples never occupy the arithmetic stages.
module five_point_stencil_sweep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpss_pkg::SAMPLE_W-1:0]     s_tdata,   // [31:0] sample
    input  logic                              s_tuser,   // [0] start_req
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpss_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] value, [47:32] row,
                                                         // [57:48] col, [63:58] zero
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fpss_pkg::*;

    // Configuration registers
    logic [GW_W-1:0]   gw_reg;
    logic [GH_W-1:0]   gh_reg;
    logic [COEF_W-1:0] alpha_reg;
    logic [COEF_W-1:0] beta_reg;

    // Position counters
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;

    // Operand stage
    logic                va_reg;
    logic                ra_reg;
    logic [SAMPLE_W-1:0] sample_a_reg;
    logic [ROW_W-1:0]    row_a_reg;
    logic [COL_W-1:0]    col_a_reg;
    logic                last_a_reg;
    logic [SAMPLE_W-1:0] west_a_reg;
    logic                byp_a_reg;

    // Previous transaction column, for the upper store bypass
    logic [COL_W-1:0]    prev_col_reg;
    logic                prev_ok_reg;

    // Deferred upper store write
    logic                upd_pend_reg;
    logic [COL_W-1:0]    upd_addr_reg;

    logic [GW_W-1:0]     w_eff;
    logic [GH_W-1:0]     h_eff;
    logic [GW_W-1:0]     w_m2;
    logic [GH_W-1:0]     h_m1;
    logic                in_accept;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;
    logic [GW_W-1:0]     col_ext;
    logic [GW_W-1:0]     col_inc;
    logic [ROW_W:0]      row_inc;
    logic                is_res;
    logic                is_last;
    logic [COL_W-1:0]    east_addr;
    logic [SAMPLE_W-1:0] mid_c_rd;
    logic [SAMPLE_W-1:0] mid_e_rd;
    logic [SAMPLE_W-1:0] up_rd;
    logic                ready_a;
    logic                upd_ready;
    fpss_cell_t          upd_cell;
    logic signed [SAMPLE_W-1:0] out_value;
    logic [ROW_W-1:0]    out_row;
    logic [COL_W-1:0]    out_col;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg    <= GRID_WIDTH_RST;
            gh_reg    <= GRID_HEIGHT_RST;
            alpha_reg <= ALPHA_RST;
            beta_reg  <= BETA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  gw_reg    <= cfg_data[GW_W-1:0];
                REG_GRID_HEIGHT: gh_reg    <= cfg_data[GH_W-1:0];
                REG_ALPHA:       alpha_reg <= cfg_data[COEF_W-1:0];
                REG_BETA:        beta_reg  <= cfg_data[COEF_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp grid size
    assign w_eff = (gw_reg < GW_MIN) ? GW_MIN : ((gw_reg > GW_MAX) ? GW_MAX : gw_reg);
    assign h_eff = (gh_reg < GH_MIN) ? GH_MIN : gh_reg;
    assign w_m2  = w_eff - 11'd2;
    assign h_m1  = h_eff - 16'd1;

    // Current position, restarted by start_req
    assign in_accept = s_tvalid && s_tready;
    assign col_cur   = s_tuser ? '0 : col_reg;
    assign row_cur   = s_tuser ? '0 : row_reg;
    assign col_ext   = {1'b0, col_cur};
    assign col_inc   = col_ext + 11'd1;
    assign row_inc   = {1'b0, row_cur} + 17'd1;
    assign east_addr = col_cur + 1'b1;

    assign is_res  = (row_cur >= 16'd2) && (row_cur <= h_m1)
                  && (col_ext >= 11'd1) && (col_ext <= w_m2);
    assign is_last = (row_cur == h_m1) && (col_ext == w_m2);

    // Advance column and row, wrapping at the end of a row and of the grid
    always_comb
    begin
        col_next = col_inc[COL_W-1:0];
        row_next = row_cur;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= {1'b0, h_eff})
                row_next = '0;
            else
                row_next = row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Middle line: two copies so center and east are read in the same cycle
    fpss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_mid_c (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (col_cur),
        .wr_data (s_tdata),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (mid_c_rd)
    );

    fpss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_mid_e (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (col_cur),
        .wr_data (s_tdata),
        .rd_en   (in_accept),
        .rd_addr (east_addr),
        .rd_data (mid_e_rd)
    );

    // Upper line: takes the old middle entry in the cycle after the transaction
    fpss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk     (clk),
        .wr_en   (upd_pend_reg),
        .wr_addr (upd_addr_reg),
        .wr_data (mid_c_rd),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (up_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_pend_reg <= 1'b0;
            prev_ok_reg  <= 1'b0;
        end
        else
        begin
            upd_pend_reg <= in_accept;
            if (in_accept)
            begin
                prev_ok_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            upd_addr_reg <= col_cur;
            prev_col_reg <= col_cur;
        end
    end

    // Operand stage; border samples drop out here at once
    assign ready_a  = !va_reg || !ra_reg || upd_ready;
    assign s_tready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (ready_a)
        begin
            va_reg <= in_accept;
        end
    end

    // West is the center of the previous transaction, still on the RAM output
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ra_reg       <= is_res;
            sample_a_reg <= s_tdata;
            row_a_reg    <= row_cur - 16'd1;
            col_a_reg    <= col_cur;
            last_a_reg   <= is_last;
            west_a_reg   <= mid_c_rd;
            byp_a_reg    <= prev_ok_reg && (prev_col_reg == col_cur);
        end
    end

    // Same column twice in a row: the upper write is still in flight, take it from west
    always_comb
    begin
        upd_cell.cen   = $signed(mid_c_rd);
        upd_cell.north = byp_a_reg ? $signed(west_a_reg) : $signed(up_rd);
        upd_cell.south = $signed(sample_a_reg);
        upd_cell.west  = $signed(west_a_reg);
        upd_cell.east  = $signed(mid_e_rd);
        upd_cell.row   = row_a_reg;
        upd_cell.col   = col_a_reg;
        upd_cell.last  = last_a_reg;
    end

    fpss_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (va_reg && ra_reg),
        .in_ready  (upd_ready),
        .in_cell   (upd_cell),
        .alpha     (alpha_reg),
        .beta      (beta_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (out_value),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, out_col, out_row, out_value};

`ifndef SYNTHESIS
    // The flagged cell is the bottom-right interior corner
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> ((m_tdata[57:48] == w_m2[COL_W-1:0])
                                && (m_tdata[47:32] == (h_eff - 16'd2))))
        else $error("last flag on a cell other than the final interior cell");

    // Every transaction schedules its upper line write at its own column
    a_upper_wr: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (upd_pend_reg && (upd_addr_reg == $past(col_cur))))
        else $error("upper line write missing or at wrong column");

    // Input stalls only when an interior cell waits on the arithmetic pipeline
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (va_reg && ra_reg && !upd_ready))
        else $error("input stalled without a waiting interior cell");
`endif

endmodule

@@ tb/tb_five_point_stencil_sweep.sv @@
// Self-checking testbench for five_point_stencil_sweep: streams grids, predicts every
// interior cell update and compares it with the block's output. Depends on fpss_pkg.
`timescale 1ns / 100ps

module tb_five_point_stencil_sweep;
    import fpss_pkg::*;

    // Sample styles for generated runs
    localparam int SMP_RANDOM  = 0;
    localparam int SMP_SMALL   = 1;
    localparam int SMP_EXTREME = 2;
    localparam int SMP_LEVEL   = 3;

    localparam int RANDOM_ITEMS   = 300;
    localparam int WIDE_COLS      = 128;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] sample;
    } grid_sample_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic                last;
    } cell_update_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    five_point_stencil_sweep dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: registers, line stores, position, west neighbor
    logic [GW_W-1:0]            grid_width_q  = GRID_WIDTH_RST;
    logic [GH_W-1:0]            grid_height_q = GRID_HEIGHT_RST;
    logic [COEF_W-1:0]          alpha_q       = ALPHA_RST;
    logic [COEF_W-1:0]          beta_q        = BETA_RST;
    logic signed [SAMPLE_W-1:0] north_row [MAX_WIDTH];
    logic signed [SAMPLE_W-1:0] center_row [MAX_WIDTH];
    logic signed [SAMPLE_W-1:0] west_q = '0;
    int unsigned                row_pos = 0;
    int unsigned                col_pos = 0;

    grid_sample_t samples_to_send [$];
    cell_update_t updates_due [$];

    bit          steady = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned errors = 0;
    int unsigned samples_taken = 0;
    int unsigned updates_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned items_queued = 0;
    int unsigned quiet_cycles = 0;
    grid_sample_t next_item;
    cell_update_t due;

    function automatic longint clamp32(input longint x);
        if (x > longint'(SAT_MAX))
            return longint'(SAT_MAX);
        if (x < longint'(SAT_MIN))
            return longint'(SAT_MIN);
        return x;
    endfunction

    // Advance the predicted sweep by one sample and queue the cell update it completes
    task automatic sweep_predict(input logic start, input logic [SAMPLE_W-1:0] smp);
        int unsigned  w, h, r, c;
        longint       south, cen, north, west, east, nsum, v;
        cell_update_t u;
        w = grid_width_q;
        if (w < GW_MIN) w = GW_MIN;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = grid_height_q;
        if (h < GH_MIN) h = GH_MIN;
        if (start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= MAX_WIDTH) col_pos = 0;
        r = row_pos;
        c = col_pos;
        south = longint'($signed(smp));
        cen   = center_row[c];
        north = north_row[c];
        west  = west_q;
        east  = (c + 1 < MAX_WIDTH) ? longint'(center_row[c + 1]) : 0;
        if (r >= 2 && r <= h - 1 && c >= 1 && c <= w - 2)
        begin
            nsum = clamp32(north + south + west + east + 2 * cen);
            v = clamp32(((longint'(alpha_q) * cen) >>> 16)
                        + ((longint'(beta_q) * nsum) >>> 16));
            u.value = v[31:0];
            u.row   = ROW_W'(r - 1);
            u.col   = COL_W'(c);
            u.last  = (r == h - 1) && (c == w - 2);
            updates_due.push_back(u);
        end
        west_q        = center_row[c];
        north_row[c]  = center_row[c];
        center_row[c] = $signed(smp);
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 32'hFFFF);
        end
        else
            col_pos = c + 1;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int style,
                                                       input logic [SAMPLE_W-1:0] level);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (style)
            SMP_RANDOM: return $urandom();
            SMP_SMALL:  return SAMPLE_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            SMP_EXTREME:
                if (r < 4) return SAT_MAX;
                else if (r < 8) return SAT_MIN;
                else return $urandom();
            default:    return level;
        endcase
    endfunction

    // Queue a run of samples, start flag on the first one if asked
    task automatic push_run(input logic start, input int unsigned len, input int style,
                            input logic [SAMPLE_W-1:0] level);
        grid_sample_t it;
        for (int unsigned i = 0; i < len; i++)
        begin
            it.start  = start && (i == 0);
            it.sample = pick_sample(style, level);
            samples_to_send.push_back(it);
        end
        items_queued += len;
    endtask

    // Write one register and mirror it into the predictor on acceptance
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  grid_width_q  = data[GW_W-1:0];
            REG_GRID_HEIGHT: grid_height_q = data[GH_W-1:0];
            REG_ALPHA:       alpha_q       = data;
            REG_BETA:        beta_q        = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_regs(input int unsigned w, input int unsigned h,
                            input int unsigned a, input int unsigned b);
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_ALPHA, CFG_DATA_W'(a));
        write_reg(REG_BETA, CFG_DATA_W'(b));
    endtask

    // Wait until every sample is taken and every update has come out, then settle
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_tvalid || updates_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int unsigned pick_coef();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 0;
        if (r == 1) return 16'hFFFF;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // Sample driver: hold the transaction until taken, insert random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sweep_predict(s_tuser, s_tdata);
                samples_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap--;
                end
                else if (samples_to_send.size() != 0)
                begin
                    next_item = samples_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.sample;
                    s_tuser  <= next_item.start;
                    send_gap = steady ? 0 : idle_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each transaction with the oldest predicted update
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (updates_due.size() == 0)
                begin
                    errors++;
                    $display({"%0t: unexpected result: expected none, ",
                              "actual value %h row %0d col %0d last %b"},
                             $time, m_tdata[31:0], m_tdata[47:32], m_tdata[57:48], m_tlast);
                end
                else
                begin
                    due = updates_due.pop_front();
                    updates_checked++;
                    if (m_tdata[31:0] !== due.value)
                    begin
                        errors++;
                        $display("%0t: value at (%0d,%0d): expected %h actual %h",
                                 $time, due.row, due.col, due.value, m_tdata[31:0]);
                    end
                    if (m_tdata[47:32] !== due.row)
                    begin
                        errors++;
                        $display("%0t: row: expected %0d actual %0d",
                                 $time, due.row, m_tdata[47:32]);
                    end
                    if (m_tdata[57:48] !== due.col)
                    begin
                        errors++;
                        $display("%0t: col: expected %0d actual %0d",
                                 $time, due.col, m_tdata[57:48]);
                    end
                    if (m_tlast !== due.last)
                    begin
                        errors++;
                        $display("%0t: last at (%0d,%0d): expected %b actual %b",
                                 $time, due.row, due.col, due.last, m_tlast);
                    end
                    if (m_tdata[63:58] !== '0)
                    begin
                        errors++;
                        $display("%0t: tdata padding: expected 0 actual %h",
                                 $time, m_tdata[63:58]);
                    end
                end
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = steady ? 0 : idle_len();
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d updates outstanding",
                     $time, quiet_cycles, updates_due.size());
            $display("FAIL five_point_stencil_sweep");
            $finish;
        end
    end

    initial
    begin
        int unsigned w_reg, h_reg, w_eff, h_eff, grids, random_base, style;
        bit          aborted;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            north_row[i]  = '0;
            center_row[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Clamped 3x3 grid, full weights: saturate high, then low on a wrapped grid
        set_regs(0, 1, 16'hFFFF, 16'hFFFF);
        push_run(1'b1, 9, SMP_LEVEL, SAT_MAX);
        push_run(1'b0, 9, SMP_LEVEL, SAT_MIN);
        wait_drained();

        // Zero center weight on random data
        set_regs(3, 3, 0, 16'hFFFF);
        push_run(1'b1, 9, SMP_RANDOM, '0);
        wait_drained();

        // Tallest grid, only its first rows streamed; zero neighbor weight
        set_regs(3, 16'hFFFF, 16'hFFFF, 0);
        push_run(1'b1, 18, SMP_EXTREME, '0);
        wait_drained();

        // Wide grid at the default weights
        set_regs(WIDE_COLS, 3, ALPHA_RST, BETA_RST);
        push_run(1'b1, 3 * WIDE_COLS, SMP_SMALL, '0);
        wait_drained();

        // Random phases: small grids, random weights, back-to-back and aborted grids
        random_base = items_queued;
        while (items_queued - random_base < RANDOM_ITEMS)
        begin
            w_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            w_eff = (w_reg < 3) ? 3 : w_reg;
            h_eff = (h_reg < 3) ? 3 : h_reg;
            steady = ($urandom_range(0, 4) == 0);
            set_regs(w_reg, h_reg, pick_coef(), pick_coef());
            grids = $urandom_range(1, 3);
            for (int unsigned g = 0; g < grids; g++)
            begin
                style = $urandom_range(0, 4) / 2;
                aborted = ($urandom_range(0, 6) == 0);
                if (aborted)
                    push_run(1'b1, $urandom_range(1, w_eff * h_eff - 1), style, '0);
                push_run((g == 0) || aborted || ($urandom_range(0, 1) == 1),
                         w_eff * h_eff, style, '0);
            end
            wait_drained();
        end

        $display("Streamed %0d samples over grids from 3x3 to %0d columns; %0d cell updates checked",
                 samples_taken, WIDE_COLS, updates_checked);
        $display("%0d register writes, with clamped, extreme and random weights", reg_writes);
        if (errors == 0 && updates_due.size() == 0)
            $display("PASS five_point_stencil_sweep");
        else
            $display("FAIL five_point_stencil_sweep");
        $finish;
    end

endmodule
